// ----- rtl/insertion_key_sorter_top_defines.svh -----
// Assertion macros for the insertion key sorter.
`ifndef INSERTION_KEY_SORTER_TOP_DEFINES_SVH
`define INSERTION_KEY_SORTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define IKS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define IKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/iks_pkg.sv -----
// Shared key type and width for the insertion key sorter.
package iks_pkg;
	localparam int KEY_W = 16;
	typedef logic signed [KEY_W-1:0] key_t;
endpackage

// ----- rtl/iks_store.sv -----
// Key store: single-port-write, registered-read memory.
module iks_store import iks_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  key_t          wd,
	input  logic [AW-1:0] ra,
	output key_t          rd
);
	key_t mem [DEPTH];
	key_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	assign rd = rd_q;
endmodule

// ----- rtl/insertion_key_sorter_top.sv -----
// Top level of the insertion key sorter: sequencer, compare unit and key store.
// Timing: each stored key that moves takes a pass through S_RD and S_CMP; the new key then
//   lands in S_CMP, or in S_PUT for slot 0; a dropped key that does not close the set stays idle.
// A closing beat then emits the n stored results, each read in S_ERD and shown in S_EOUT.
// Throughput: one key per insertion walk; the single store port and compare set it.
// Reset (arst_n low, async): store empty, overflow clear, idle; results cannot stall.
`include "insertion_key_sorter_top_defines.svh"

module insertion_key_sorter_top import iks_pkg::*; #(
	parameter int MAX_ITEMS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  key_t key_in,
	input  logic last_in,
	output logic valid,
	output key_t key_out,
	output logic last_out,
	output logic overflow
);
	localparam int IW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	// One-hot sequencer states.
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,  // waiting for a beat
		S_RD   = 6'b000010,  // read entry pos-1
		S_CMP  = 6'b000100,  // compare it against the new key
		S_PUT  = 6'b001000,  // drop the new key into slot 0
		S_ERD  = 6'b010000,  // read next entry for output
		S_EOUT = 6'b100000   // present one result
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic          drop_q;
	logic [IW-1:0] pos_q;
	logic [IW-1:0] idx_q;
	key_t          key_q;
	logic          last_q;

	// Store port signals.
	logic          st_we;
	logic [IW-1:0] st_wa;
	key_t          st_wd;
	logic [IW-1:0] st_ra;
	key_t          st_rd;

	logic accept;
	logic full;
	logic gt;        // shared compare: stored entry > new key
	logic out_last;

	assign accept   = start && (state_q == S_IDLE);
	assign full     = (count_q == CW'(MAX_ITEMS));
	assign gt       = (st_rd > key_q);
	assign out_last = ((CW'(idx_q) + CW'(1)) == count_q);

	iks_store #(
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk(clk),
		.we (st_we),
		.wa (st_wa),
		.wd (st_wd),
		.ra (st_ra),
		.rd (st_rd)
	);

	// Store access: shift the larger entry up one place, or land the new key.
	always_comb begin
		st_we = 1'b0;
		st_wa = pos_q;
		st_wd = key_q;
		st_ra = idx_q;
		unique case (state_q)
			S_RD: begin
				st_ra = pos_q - IW'(1);
			end
			S_CMP: begin
				st_we = 1'b1;
				st_wd = gt ? st_rd : key_q;
			end
			S_PUT: begin
				st_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= key_in;
			last_q <= last_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			drop_q  <= 1'b0;
			pos_q   <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (full) begin
							// no room: drop the key, still close the set if asked
							drop_q  <= 1'b1;
							state_q <= last_in ? S_ERD : S_IDLE;
						end else begin
							pos_q   <= count_q[IW-1:0];
							state_q <= (count_q == '0) ? S_PUT : S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (gt) begin
						pos_q   <= pos_q - IW'(1);
						state_q <= (pos_q == IW'(1)) ? S_PUT : S_RD;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= last_q ? S_ERD : S_IDLE;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= last_q ? S_ERD : S_IDLE;
				end
				S_ERD: begin
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					if (out_last) begin
						count_q <= '0;
						drop_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= S_ERD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign valid    = (state_q == S_EOUT);
	assign key_out  = st_rd;
	assign last_out = valid && out_last;
	assign overflow = drop_q;

	// Checks on the sequencer and fill count.
	`IKS_ASSERT_NOW(a_cnt_range, 1'b1, count_q <= CW'(MAX_ITEMS), "fill count above capacity")
	`IKS_ASSERT_NOW(a_out_nonempty, valid, count_q != '0, "result from an empty store")
	`IKS_ASSERT_NEXT(a_run_clears, valid && last_out, count_q == '0 && !drop_q && !busy,
		"store not emptied after final result")
	`IKS_ASSERT_NEXT(a_insert_busy, accept && !full, busy, "insertion did not hold busy")
endmodule

// ----- verif/testbench.sv -----
// Testbench for insertion_key_sorter_top: directed and random key sets vs a sorting predictor.
`timescale 1ns / 100ps

module testbench;
	import iks_pkg::*;

	localparam int STORE_DEPTH = 32;
	// Longest insertion walk plus margin; used for the closing pause.
	localparam int DRAIN_CYCLES = 2 * STORE_DEPTH + 8;
	// Cycles with no input beat and no result beat before the run is declared hung.
	localparam int HANG_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	key_t key_in = '0;
	logic last_in = 1'b0;
	logic valid;
	key_t key_out;
	logic last_out;
	logic overflow;

	typedef struct {
		key_t key;
		logic last;
		logic ovf;
	} sorted_beat_t;

	// Predictor state: keys of the open set in ascending order, plus the drop flag.
	key_t sorted_store[$];
	logic keys_dropped = 1'b0;
	// Sorted results of closed sets, oldest first.
	sorted_beat_t sorted_results[$];

	int errors = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int sets_closed = 0;
	int overflow_sets = 0;
	int hang_count = 0;
	bit burst_mode = 1'b0;

	insertion_key_sorter_top #(
		.MAX_ITEMS(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.key_in(key_in),
		.last_in(last_in),
		.valid(valid),
		.key_out(key_out),
		.last_out(last_out),
		.overflow(overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Insert one accepted key into the predicted store; a closing beat flushes
	// the whole store, ascending, into the result queue.
	task automatic sort_accepted_key(input key_t k, input logic closes);
		int pos;
		int n;
		sorted_beat_t b;
		if (sorted_store.size() >= STORE_DEPTH) begin
			keys_dropped = 1'b1;
		end else begin
			// Equal keys stay behind earlier ones: skip every stored key <= k.
			pos = 0;
			while (pos < sorted_store.size() && sorted_store[pos] <= k)
				pos++;
			sorted_store.insert(pos, k);
		end
		if (closes) begin
			n = sorted_store.size();
			for (int i = 0; i < n; i++) begin
				b.key = sorted_store[i];
				b.last = (i == n - 1);
				b.ovf = keys_dropped;
				sorted_results.insert(sorted_results.size(), b);
			end
			sets_closed++;
			if (keys_dropped)
				overflow_sets++;
			sorted_store.delete();
			keys_dropped = 1'b0;
		end
	endtask

	// Offer one key beat. Called in the time step of a rising edge; returns in
	// the time step of the edge that accepted the beat, with start left high
	// so a back-to-back beat needs no second assignment in that step.
	task automatic send_key(input key_t k, input logic closes);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		key_in <= k;
		last_in <= closes;
		@(posedge clk);
		// busy read here is the value before this edge.
		while (busy)
			@(posedge clk);
		beats_sent++;
		sort_accepted_key(k, closes);
	endtask

	// Biased key draw: extremes, a narrow band for duplicates, else full range.
	function automatic key_t rand_key();
		case ($urandom_range(0, 9))
			0: rand_key = key_t'(16'h8000);
			1: rand_key = key_t'(16'h7fff);
			2, 3: rand_key = key_t'(int'($urandom_range(0, 7)) - 4);
			default: rand_key = key_t'($urandom);
		endcase
	endfunction

	task automatic send_random_set(input int n);
		for (int i = 0; i < n; i++)
			send_key(rand_key(), i == n - 1);
	endtask

	// A set of one key: smallest, largest and zero key each alone.
	task automatic test_single_key();
		burst_mode = 1'b0;
		send_key(key_t'(16'h8000), 1'b1);
		send_key(key_t'(16'h7fff), 1'b1);
		send_key(key_t'(0), 1'b1);
	endtask

	// Extremes and sign boundaries in one set, arriving out of order.
	task automatic test_extreme_keys();
		burst_mode = 1'b0;
		send_key(key_t'(16'h7fff), 1'b0);
		send_key(key_t'(1), 1'b0);
		send_key(key_t'(16'h8000), 1'b0);
		send_key(key_t'(-1), 1'b0);
		send_key(key_t'(0), 1'b0);
		send_key(key_t'(16'h8001), 1'b0);
		send_key(key_t'(16'h7ffe), 1'b0);
		send_key(key_t'(16'h5555), 1'b0);
		send_key(key_t'(16'haaaa), 1'b1);
	endtask

	// Repeated keys, ending with a smallest key that walks the whole store.
	task automatic test_duplicates();
		burst_mode = 1'b1;
		send_key(key_t'(5), 1'b0);
		send_key(key_t'(5), 1'b0);
		send_key(key_t'(3), 1'b0);
		send_key(key_t'(5), 1'b0);
		send_key(key_t'(3), 1'b0);
		send_key(key_t'(-2), 1'b1);
	endtask

	// Store full: exactly full with no drop, then full with the closing key dropped.
	task automatic test_store_full();
		burst_mode = 1'b1;
		for (int i = 0; i < STORE_DEPTH; i++)
			send_key(key_t'(STORE_DEPTH - i), i == STORE_DEPTH - 1);
		burst_mode = 1'b0;
		for (int i = 0; i <= STORE_DEPTH; i++)
			send_key(rand_key(), i == STORE_DEPTH);
	endtask

	// Random sets: mostly short, about one in ten near or past capacity.
	task automatic test_random_sets(input int item_goal);
		int n;
		int sent;
		sent = 0;
		while (sent < item_goal) begin
			burst_mode = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				n = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 4);
			else
				n = $urandom_range(1, 8);
			send_random_set(n);
			sent += n;
		end
	endtask

	// Result checker: every strobe is one beat, compared with the oldest expectation.
	always @(posedge clk) begin
		sorted_beat_t exp_beat;
		if (arst_n && valid) begin
			results_seen++;
			if (sorted_results.size() == 0) begin
				$error("unexpected result beat: key_out %0d", key_out);
				errors++;
			end else begin
				exp_beat = sorted_results.pop_front();
				if (key_out !== exp_beat.key) begin
					$error("key_out: expected %0d, got %0d", exp_beat.key, key_out);
					errors++;
				end
				if (last_out !== exp_beat.last) begin
					$error("last_out: expected %0b, got %0b", exp_beat.last, last_out);
					errors++;
				end
				if (overflow !== exp_beat.ovf) begin
					$error("overflow: expected %0b, got %0b", exp_beat.ovf, overflow);
					errors++;
				end
			end
		end
	end

	// Watchdog: no input beat and no result for too long means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || valid)
				hang_count <= 0;
			else
				hang_count <= hang_count + 1;
			if (hang_count >= HANG_LIMIT) begin
				$display("watchdog: %0d results still outstanding", sorted_results.size());
				$display("insertion_key_sorter_top: mismatch");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_key();
		test_extreme_keys();
		test_duplicates();
		test_store_full();
		test_random_sets(200);

		start <= 1'b0;
		while (sorted_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d key beats in %0d sets (%0d with dropped keys)",
			beats_sent, sets_closed, overflow_sets);
		$display("checked %0d sorted result beats", results_seen);
		if (errors == 0 && sorted_results.size() == 0)
			$display("insertion_key_sorter_top: match");
		else
			$display("insertion_key_sorter_top: mismatch");
		$finish;
	end

endmodule
